### src/fae_pkg.sv
// ----------------------------------------------------------------------------
// fae_pkg
// Shared widths, constants and controller/datapath interface types for the
// filtered acceleration estimator.
// ----------------------------------------------------------------------------
package fae_pkg;

  localparam int SPEED_W  = 16;
  localparam int STAMP_W  = 32;
  localparam int ACC_W    = 32;
  localparam int WEIGHT_W = 17;
  localparam int FILT_W   = 32;   // Q16.16 filtered speed

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd16384;
  localparam logic [19:0]         USEC_PER_SEC = 20'd1000000;

  // |df * 1e6| < 2^52; dividing by dt * 2^16 is (|num| >> 16) / dt
  localparam int NUM_W    = 54;
  localparam int DIV_BITS = 36;
  localparam int DT_W     = 31;
  localparam int CNT_W    = $clog2(DIV_BITS);

  typedef struct packed {
    logic load;      // latch the incoming sample
    logic prime;     // first sample: set filter and stamp directly
    logic mul;       // weight * (x - F)
    logic upd;       // update F and stamp, form df * 1e6
    logic div_init;  // take magnitude, load divider
    logic div_step;  // one restoring divide step
    logic out_load;  // sign, saturate, present result
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic emit;      // time difference is positive
    logic out_busy;  // result register full and stalled
  } status_t;

endpackage

### src/filtered_acceleration_estimator.sv
// ----------------------------------------------------------------------------
// filtered_acceleration_estimator
// Low-pass filters timestamped speed samples and reports the rate of change
// of the filtered speed as a saturated signed Q32.0 acceleration, in speed units per second.
//
//   channel  ports                          direction  width
//   in       in_valid/in_stall, in_speed,   input      16 + 32
//            in_stamp_us
//   out      out_valid/out_stall,           output     32
//            out_acceleration
//   config   psel/penable/pwrite/paddr,     APB-style  32 (weight at 0x0)
//            pwdata/prdata/pready
//
// One request at a time. A priming sample ends once it has set the filter; a
// sample with no result (time not advancing) ends after the update; a sample
// with a result goes on through the 36-step bit-serial restoring divider.
// Synchronous active-low reset clears the filter, stamp and weight (to 0.25).
// A stalled result holds the finished request in its last cycle; the input is stalled while busy.
// ----------------------------------------------------------------------------
module filtered_acceleration_estimator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fae_pkg::SPEED_W-1:0]  in_speed,
  input  logic [fae_pkg::STAMP_W-1:0]         in_stamp_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fae_pkg::ACC_W-1:0]    out_acceleration,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import fae_pkg::*;

  cmd_t                cmd;
  status_t             status;
  logic [WEIGHT_W-1:0] weight;

  fae_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .weight  (weight)
  );

  fae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fae_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .weight           (weight),
    .in_speed         (in_speed),
    .in_stamp_us      (in_stamp_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_acceleration (out_acceleration)
  );

endmodule

### src/fae_regs.sv
// ----------------------------------------------------------------------------
// fae_regs
// APB-style configuration register: filter weight, clamped to one on use.
// ----------------------------------------------------------------------------
module fae_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [fae_pkg::WEIGHT_W-1:0]    weight
);
  import fae_pkg::*;

  localparam logic ADDR_WEIGHT = 1'b0;

  logic [WEIGHT_W-1:0] weight_r;
  logic [WEIGHT_W-1:0] weight_nxt;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == ADDR_WEIGHT);

  always_comb begin
    weight_nxt = weight_r;
    if (wr_en) begin
      weight_nxt = pwdata[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else begin
      weight_r <= weight_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_WEIGHT: prdata = {{(32-WEIGHT_W){1'b0}}, weight_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign weight = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;

endmodule

### src/fae_ctrl.sv
// ----------------------------------------------------------------------------
// fae_ctrl
// Sequencer: prime, or filter and update and, when time advances, a bit-serial divide per request.
// ----------------------------------------------------------------------------
module fae_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fae_pkg::status_t     status,
  output fae_pkg::cmd_t        cmd
);
  import fae_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_BITS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (!status.primed) begin
          cmd.prime = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = status.emit ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the previous result has been taken
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### src/fae_dp.sv
// ----------------------------------------------------------------------------
// fae_dp
// Datapath: low-pass filter state, time stamp, scale multiply, restoring
// divider and the saturating result register.
// ----------------------------------------------------------------------------
module fae_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fae_pkg::cmd_t                       cmd,
  output fae_pkg::status_t                    status,
  input  logic [fae_pkg::WEIGHT_W-1:0]        weight,
  input  logic signed [fae_pkg::SPEED_W-1:0]  in_speed,
  input  logic [fae_pkg::STAMP_W-1:0]         in_stamp_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fae_pkg::ACC_W-1:0]    out_acceleration
);
  import fae_pkg::*;

  localparam int PROD_W = FILT_W + 1 + WEIGHT_W + 1;   // 33 x 18 signed

  // control state
  logic                    primed_r;
  logic                    out_valid_r;
  // payload
  logic [FILT_W-1:0]       x_r;
  logic [STAMP_W-1:0]      stamp_r;
  logic [FILT_W-1:0]       f_r;
  logic [STAMP_W-1:0]      prev_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NUM_W-1:0] num_r;
  logic [DT_W-1:0]         dt_r;
  logic [DT_W-1:0]         rem_r;
  logic [DIV_BITS-1:0]     quo_r;
  logic                    neg_r;
  logic [ACC_W-1:0]        acc_r;

  logic signed [FILT_W:0]      diff_x;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic signed [PROD_W-17:0]   delta;
  logic signed [FILT_W:0]      df;
  logic signed [NUM_W-1:0]     num_nxt;
  logic [STAMP_W-1:0]          dt_full;
  logic [NUM_W-1:0]            num_mag;
  logic [DT_W:0]               rem_sh;
  logic [DT_W+1:0]             trial;
  logic                        ge;
  logic [ACC_W-1:0]            acc_nxt;

  // filter step
  assign diff_x   = $signed({x_r[FILT_W-1], x_r}) - $signed({f_r[FILT_W-1], f_r});
  assign prod_nxt = diff_x * $signed({1'b0, weight});
  assign delta    = prod_r[PROD_W-1:16];              // floor(w*d / 2^16)
  assign df       = delta[FILT_W:0];
  // widen both factors first so the product keeps all its bits
  assign num_nxt  = NUM_W'(df) * NUM_W'($signed({1'b0, USEC_PER_SEC}));

  assign dt_full  = stamp_r - prev_r;

  assign status.primed   = primed_r;
  assign status.emit     = (dt_full != '0) && !dt_full[STAMP_W-1];
  assign status.out_busy = out_valid_r && out_stall;

  // restoring divide step
  assign num_mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign rem_sh  = {rem_r, quo_r[DIV_BITS-1]};
  assign trial   = {1'b0, rem_sh} - {2'b00, dt_r};
  assign ge      = !trial[DT_W+1];

  // sign and saturate
  always_comb begin
    if (neg_r) begin
      if (quo_r > DIV_BITS'(33'h080000000)) begin
        acc_nxt = 32'h80000000;
      end else begin
        acc_nxt = ACC_W'(-quo_r);
      end
    end else begin
      if (quo_r > DIV_BITS'(32'h7fffffff)) begin
        acc_nxt = 32'h7fffffff;
      end else begin
        acc_nxt = quo_r[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      f_r         <= '0;
      prev_r      <= '0;
    end else begin
      if (cmd.prime) begin
        primed_r <= 1'b1;
        f_r      <= x_r;
        prev_r   <= stamp_r;
      end
      if (cmd.upd) begin
        f_r    <= f_r + delta[FILT_W-1:0];
        prev_r <= stamp_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= {in_speed, 16'h0000};
      stamp_r <= in_stamp_us;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.upd) begin
      num_r <= num_nxt;
      dt_r  <= dt_full[DT_W-1:0];
    end
    if (cmd.div_init) begin
      neg_r <= num_r[NUM_W-1];
      rem_r <= '0;
      quo_r <= num_mag[DIV_BITS+15:16];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? trial[DT_W-1:0] : rem_sh[DT_W-1:0];
      quo_r <= {quo_r[DIV_BITS-2:0], ge};
    end
    if (cmd.out_load) begin
      acc_r <= acc_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_acceleration = acc_r;

endmodule
